/* rtl/segment_intersect_with_tolerance_defines.svh */
// Assertion macros for the segment intersection block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SEGMENT_INTERSECT_WITH_TOLERANCE_DEFINES_SVH
`define SEGMENT_INTERSECT_WITH_TOLERANCE_DEFINES_SVH
`ifndef SYNTH
`define SIT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SIT_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
    else $error("assertion failed");
`else
`define SIT_ASSERT(name, clk, rstn, prop)
`define SIT_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif
`endif

/* rtl/sit_pkg.sv */
// Shared types and constants of the segment intersection block.
// No dependencies.
package sit_pkg;

  localparam int PARAM_FRAC  = 24;
  localparam int PARAM_WIDTH = 32;
  localparam int TOL_WIDTH   = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_FROM_FIRST = 2'd1;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_INTERIOR,
    CLS_AT_START,
    CLS_AT_END
  } hit_class_e;

  typedef struct packed {
    logic degen;
    logic t1_out;
    logic t2_out;
  } hit_flags_t;

endpackage

/* rtl/sit_delay.sv */
// Fixed-depth register delay line for side data of the pipeline.
// No dependencies.
module sit_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i) begin
    sh_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sh_q[i] <= sh_q[i-1];
    end
  end

  assign q_o = sh_q[DEPTH-1];

endmodule

/* rtl/sit_mulw.sv */
// Two-stage wide by narrow signed multiplier built from two partial products.
// No dependencies.
module sit_mulw #(
  parameter int NW = 67,
  parameter int VW = 33
) (
  input  logic                    clk_i,
  input  logic signed [NW-1:0]    n_i,
  input  logic signed [VW-1:0]    v_i,
  output logic signed [NW+VW-1:0] m_o
);

  localparam int H  = NW / 2;
  localparam int MW = NW + VW;

  logic signed [H+VW:0]      pl_d, pl_q;
  logic signed [NW-H+VW-1:0] ph_d, ph_q;
  logic signed [MW-1:0]      m_d, m_q;

  always_comb begin
    pl_d = $signed({1'b0, n_i[H-1:0]}) * v_i;
    ph_d = $signed(n_i[NW-1:H]) * v_i;
    m_d  = (MW'(ph_q) <<< H) + MW'(pl_q);
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    ph_q <= ph_d;
    m_q  <= m_d;
  end

  assign m_o = m_q;

endmodule

/* rtl/sit_fdiv.sv */
// Pipelined floor divider, one quotient bit per stage, lanes share the divisor.
// Quotients whose magnitude needs more than QB bits are clamped. No dependencies.
module sit_fdiv #(
  parameter int NW = 100,
  parameter int PW = 67,
  parameter int QB = 34,
  parameter int NL = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i [NL],
  input  logic [PW-1:0]        den_i,
  output logic                 valid_o,
  output logic signed [QB:0]   quo_o [NL]
);

  localparam int HW   = NW - QB;
  localparam int CWID = (HW > PW) ? HW : PW;

  logic              pv_q;
  logic [NW-1:0]     t_q   [NL];
  logic              pn_q  [NL];
  logic [PW-1:0]     pd_q;

  logic              vld_q [QB+1];
  logic [PW-1:0]     d_q   [QB+1];
  logic [PW-1:0]     rem_q [QB+1][NL];
  logic [QB-1:0]     tl_q  [QB+1][NL];
  logic [QB-1:0]     q_q   [QB+1][NL];
  logic              ovf_q [QB+1][NL];
  logic              neg_q [QB+1][NL];

  logic              fv_q;
  logic signed [QB:0] quo_q [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q     <= 1'b0;
      vld_q[0] <= 1'b0;
      fv_q     <= 1'b0;
    end else begin
      pv_q     <= valid_i;
      vld_q[0] <= pv_q;
      fv_q     <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CWID-1:0] hi;
    pd_q <= den_i;
    d_q[0] <= pd_q;
    for (int l = 0; l < NL; l++) begin
      pn_q[l] <= num_i[l][NW-1];
      t_q[l]  <= num_i[l][NW-1] ? (~num_i[l] + NW'(den_i)) : num_i[l];
      hi = CWID'(t_q[l][NW-1:QB]);
      ovf_q[0][l] <= hi >= CWID'(pd_q);
      rem_q[0][l] <= hi[PW-1:0];
      tl_q[0][l]  <= t_q[l][QB-1:0];
      q_q[0][l]   <= '0;
      neg_q[0][l] <= pn_q[l];
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [PW-1:0] sh;
      logic [PW:0]   diff;
      d_q[k] <= d_q[k-1];
      for (int l = 0; l < NL; l++) begin
        sh   = {rem_q[k-1][l][PW-2:0], tl_q[k-1][l][QB-1]};
        diff = {1'b0, sh} - {1'b0, d_q[k-1]};
        rem_q[k][l] <= diff[PW] ? sh : diff[PW-1:0];
        q_q[k][l]   <= {q_q[k-1][l][QB-2:0], ~diff[PW]};
        tl_q[k][l]  <= {tl_q[k-1][l][QB-2:0], 1'b0};
        ovf_q[k][l] <= ovf_q[k-1][l];
        neg_q[k][l] <= neg_q[k-1][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [QB-1:0] qm;
    for (int l = 0; l < NL; l++) begin
      qm = ovf_q[QB][l] ? {QB{1'b1}} : q_q[QB][l];
      quo_q[l] <= neg_q[QB][l] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end
  end

  assign valid_o = fv_q;
  assign quo_o   = quo_q;

endmodule

/* rtl/segment_intersect_with_tolerance.sv */
// Top level of the XY segment intersection block with endpoint tolerance.
// Uses sit_pkg, sit_delay, sit_mulw, sit_fdiv and the assertion macro header.
//
// Channel   Direction  Handshake                  Payload
// input     in         start_i, busy_o            ax_i .. dz_i
// result    out        valid_o (one-cycle strobe)  hit_class_o, hit_x_o .. hit_param_o
// config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item can be started in every cycle; busy_o stays low.
// Most of the pipeline is the floor divider with max(COORD_WIDTH, 32) + 2 quotient stages.
// Reset clears the valid bits of all stages and loads the register defaults.
// Results cannot be stalled, so the pipeline advances in every cycle.
module segment_intersect_with_tolerance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  input  logic signed [COORD_WIDTH-1:0] dx_i,
  input  logic signed [COORD_WIDTH-1:0] dy_i,
  input  logic signed [COORD_WIDTH-1:0] dz_i,
  output logic                          valid_o,
  output logic [1:0]                    hit_class_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o,
  output logic signed [sit_pkg::PARAM_WIDTH-1:0] hit_param_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sit_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sit_pkg::CFG_DATA_W-1:0] cfg_data_i
);

`include "segment_intersect_with_tolerance_defines.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW + 1;
  localparam int MW  = PW + DW;
  localparam int NW  = PW + ((DW > sit_pkg::PARAM_FRAC) ? DW : sit_pkg::PARAM_FRAC);
  localparam int QB  = ((CW > sit_pkg::PARAM_WIDTH) ? CW : sit_pkg::PARAM_WIDTH) + 2;
  localparam int XW  = QB + 2;
  localparam int EW  = QB + 3;
  localparam int TW  = sit_pkg::PARAM_WIDTH;
  localparam int LAT = QB + 13;

  localparam logic signed [XW-1:0] XMAX = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] XMIN = XW'(-(64'sd1 <<< (CW - 1)));
  localparam logic signed [QB:0]   TMAX = (QB+1)'((64'sd1 <<< (TW - 1)) - 64'sd1);
  localparam logic signed [QB:0]   TMIN = (QB+1)'(-(64'sd1 <<< (TW - 1)));

  // Configuration registers.
  logic [sit_pkg::TOL_WIDTH-1:0] tol_q;
  logic                          zff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
      zff_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sit_pkg::CFG_TOLERANCE:    tol_q <= cfg_data_i[sit_pkg::TOL_WIDTH-1:0];
        sit_pkg::CFG_Z_FROM_FIRST: zff_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Valid bits of the stages outside the divider.
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q;
  logic vlde_q, vldf_q, vldg_q, vldh_q;
  logic div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vlde_q <= 1'b0;
      vldf_q <= 1'b0;
      vldg_q <= 1'b0;
      vldh_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vlde_q <= div_vld;
      vldf_q <= vlde_q;
      vldg_q <= vldf_q;
      vldh_q <= vldg_q;
    end
  end

  // Stage 1: differences.
  logic signed [DW-1:0] v1x_s1_q, v1y_s1_q, vz_s1_q, v2x_s1_q, v2y_s1_q, wx_s1_q, wy_s1_q;
  logic                 zsel_s1_q;

  always_ff @(posedge clk_i) begin
    v1x_s1_q  <= DW'(bx_i) - DW'(ax_i);
    v1y_s1_q  <= DW'(by_i) - DW'(ay_i);
    v2x_s1_q  <= DW'(dx_i) - DW'(cx_i);
    v2y_s1_q  <= DW'(dy_i) - DW'(cy_i);
    wx_s1_q   <= DW'(cx_i) - DW'(ax_i);
    wy_s1_q   <= DW'(cy_i) - DW'(ay_i);
    vz_s1_q   <= zff_q ? (DW'(bz_i) - DW'(az_i)) : (DW'(dz_i) - DW'(cz_i));
    zsel_s1_q <= zff_q;
  end

  // Points and z base travel alongside until the divider results are out.
  logic [9*CW-1:0] pts_d, pts;
  assign pts_d = {ax_i, ay_i, bx_i, by_i, cx_i, cy_i, dx_i, dy_i, (zff_q ? az_i : cz_i)};

  sit_delay #(.WIDTH(9*CW), .DEPTH(QB+9)) u_pts_dly (
    .clk_i (clk_i),
    .d_i   (pts_d),
    .q_o   (pts)
  );

  logic [3*DW:0] vec_q;
  logic signed [DW-1:0] v1x_4, v1y_4, vz_4;
  logic zsel_4;

  sit_delay #(.WIDTH(3*DW+1), .DEPTH(3)) u_vec_dly (
    .clk_i (clk_i),
    .d_i   ({v1x_s1_q, v1y_s1_q, vz_s1_q, zsel_s1_q}),
    .q_o   (vec_q)
  );

  assign v1x_4  = $signed(vec_q[3*DW -: DW]);
  assign v1y_4  = $signed(vec_q[2*DW -: DW]);
  assign vz_4   = $signed(vec_q[DW -: DW]);
  assign zsel_4 = vec_q[0];

  // Stage 2: cross products.
  logic signed [2*DW-1:0] p0_s2_q, p1_s2_q, p2_s2_q, p3_s2_q, p4_s2_q, p5_s2_q;

  always_ff @(posedge clk_i) begin
    p0_s2_q <= v1x_s1_q * v2y_s1_q;
    p1_s2_q <= v1y_s1_q * v2x_s1_q;
    p2_s2_q <= wx_s1_q * v2y_s1_q;
    p3_s2_q <= wy_s1_q * v2x_s1_q;
    p4_s2_q <= wx_s1_q * v1y_s1_q;
    p5_s2_q <= wy_s1_q * v1x_s1_q;
  end

  // Stage 3: determinant and numerators.
  logic signed [PW-1:0] del_s3_q, n1_s3_q, n2_s3_q;

  always_ff @(posedge clk_i) begin
    del_s3_q <= PW'(p0_s2_q) - PW'(p1_s2_q);
    n1_s3_q  <= PW'(p2_s2_q) - PW'(p3_s2_q);
    n2_s3_q  <= PW'(p4_s2_q) - PW'(p5_s2_q);
  end

  // Stage 4: make the determinant positive.
  logic signed [PW-1:0] dab_s4_q, n1_s4_q, n2_s4_q;
  logic                 deg_s4_q;

  always_ff @(posedge clk_i) begin
    dab_s4_q <= del_s3_q[PW-1] ? -del_s3_q : del_s3_q;
    n1_s4_q  <= del_s3_q[PW-1] ? -n1_s3_q : n1_s3_q;
    n2_s4_q  <= del_s3_q[PW-1] ? -n2_s3_q : n2_s3_q;
    deg_s4_q <= del_s3_q == '0;
  end

  // Range decisions on the exact values, carried to the divider output.
  sit_pkg::hit_flags_t fl_d, fl;

  always_comb begin
    fl_d.degen  = deg_s4_q;
    fl_d.t1_out = n1_s4_q[PW-1] || (n1_s4_q == '0) || (n1_s4_q >= dab_s4_q);
    fl_d.t2_out = n2_s4_q[PW-1] || (n2_s4_q > dab_s4_q);
  end

  sit_delay #(.WIDTH($bits(sit_pkg::hit_flags_t)), .DEPTH(QB+5)) u_flag_dly (
    .clk_i (clk_i),
    .d_i   (fl_d),
    .q_o   (fl)
  );

  // Stages 5 and 6: numerator products.
  logic signed [MW-1:0] mx, my, mz;
  logic [2*PW-1:0]      dn_q;
  logic [PW-1:0]        dab_6;
  logic signed [PW-1:0] n1_6;

  sit_mulw #(.NW(PW), .VW(DW)) u_mul_x (
    .clk_i (clk_i), .n_i (n1_s4_q), .v_i (v1x_4), .m_o (mx)
  );

  sit_mulw #(.NW(PW), .VW(DW)) u_mul_y (
    .clk_i (clk_i), .n_i (n1_s4_q), .v_i (v1y_4), .m_o (my)
  );

  sit_mulw #(.NW(PW), .VW(DW)) u_mul_z (
    .clk_i (clk_i), .n_i (zsel_4 ? n1_s4_q : n2_s4_q), .v_i (vz_4), .m_o (mz)
  );

  sit_delay #(.WIDTH(2*PW), .DEPTH(2)) u_den_dly (
    .clk_i (clk_i),
    .d_i   ({dab_s4_q, n1_s4_q}),
    .q_o   (dn_q)
  );

  assign dab_6 = dn_q[2*PW-1:PW];
  assign n1_6  = $signed(dn_q[PW-1:0]);

  // Floor division of all four lanes.
  logic signed [NW-1:0] num [4];
  logic signed [QB:0]   quo [4];

  assign num[0] = NW'(mx);
  assign num[1] = NW'(my);
  assign num[2] = NW'(mz);
  assign num[3] = NW'(n1_6) <<< sit_pkg::PARAM_FRAC;

  sit_fdiv #(.NW(NW), .PW(PW), .QB(QB), .NL(4)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld6_q),
    .num_i   (num),
    .den_i   (dab_6),
    .valid_o (div_vld),
    .quo_o   (quo)
  );

  // Stage E: intersection point.
  logic signed [XW-1:0] xre_q, yre_q, zre_q;
  logic signed [QB:0]   tpe_q;
  logic [8*CW-1:0]      pte_q;
  sit_pkg::hit_flags_t  fle_q;

  always_ff @(posedge clk_i) begin
    xre_q <= XW'($signed(pts[8*CW +: CW])) + XW'(quo[0]);
    yre_q <= XW'($signed(pts[7*CW +: CW])) + XW'(quo[1]);
    zre_q <= XW'($signed(pts[0 +: CW])) + XW'(quo[2]);
    tpe_q <= quo[3];
    pte_q <= pts[9*CW-1:CW];
    fle_q <= fl;
  end

  // Stage F: offsets to the four endpoints.
  logic signed [EW-1:0] exf_q [4];
  logic signed [EW-1:0] eyf_q [4];
  logic signed [XW-1:0] xrf_q, yrf_q, zrf_q;
  logic signed [QB:0]   tpf_q;
  sit_pkg::hit_flags_t  flf_q;

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 4; p++) begin
      exf_q[p] <= EW'(xre_q) - EW'($signed(pte_q[(7-2*p)*CW +: CW]));
      eyf_q[p] <= EW'(yre_q) - EW'($signed(pte_q[(6-2*p)*CW +: CW]));
    end
    xrf_q <= xre_q;
    yrf_q <= yre_q;
    zrf_q <= zre_q;
    tpf_q <= tpe_q;
    flf_q <= fle_q;
  end

  // Stage G: tolerance tests, endpoints in order A, B, C, D.
  logic signed [EW-1:0] tolp, toln;
  logic [3:0]           near_q;
  logic signed [XW-1:0] xrg_q, yrg_q, zrg_q;
  logic signed [QB:0]   tpg_q;
  sit_pkg::hit_flags_t  flg_q;

  assign tolp = $signed(EW'(tol_q));
  assign toln = -tolp;

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 4; p++) begin
      near_q[p] <= (exf_q[p] <= tolp) && (exf_q[p] >= toln) &&
                   (eyf_q[p] <= tolp) && (eyf_q[p] >= toln);
    end
    xrg_q <= xrf_q;
    yrg_q <= yrf_q;
    zrg_q <= zrf_q;
    tpg_q <= tpf_q;
    flg_q <= flf_q;
  end

  // Stage H: classification and saturation.
  sit_pkg::hit_class_e  cls;
  logic signed [CW-1:0] xs, ys, zs;
  logic signed [TW-1:0] ts;

  always_comb begin
    priority if (flg_q.degen) begin
      cls = sit_pkg::CLS_NONE;
    end else if (flg_q.t2_out && !near_q[2] && !near_q[3]) begin
      cls = sit_pkg::CLS_NONE;
    end else if (flg_q.t1_out && near_q[0]) begin
      cls = sit_pkg::CLS_AT_START;
    end else if (flg_q.t1_out && near_q[1]) begin
      cls = sit_pkg::CLS_AT_END;
    end else if (flg_q.t1_out) begin
      cls = sit_pkg::CLS_NONE;
    end else begin
      cls = sit_pkg::CLS_INTERIOR;
    end
    xs = (xrg_q > XMAX) ? XMAX[CW-1:0] : (xrg_q < XMIN) ? XMIN[CW-1:0] : xrg_q[CW-1:0];
    ys = (yrg_q > XMAX) ? XMAX[CW-1:0] : (yrg_q < XMIN) ? XMIN[CW-1:0] : yrg_q[CW-1:0];
    zs = (zrg_q > XMAX) ? XMAX[CW-1:0] : (zrg_q < XMIN) ? XMIN[CW-1:0] : zrg_q[CW-1:0];
    ts = (tpg_q > TMAX) ? TMAX[TW-1:0] : (tpg_q < TMIN) ? TMIN[TW-1:0] : tpg_q[TW-1:0];
  end

  logic [1:0]           cls_q;
  logic signed [CW-1:0] hx_q, hy_q, hz_q;
  logic signed [TW-1:0] hp_q;

  always_ff @(posedge clk_i) begin
    cls_q <= cls;
    hx_q  <= (cls == sit_pkg::CLS_NONE) ? '0 : xs;
    hy_q  <= (cls == sit_pkg::CLS_NONE) ? '0 : ys;
    hz_q  <= (cls == sit_pkg::CLS_NONE) ? '0 : zs;
    hp_q  <= (cls == sit_pkg::CLS_NONE) ? '0 : ts;
  end

  assign valid_o     = vldh_q;
  assign hit_class_o = cls_q;
  assign hit_x_o     = hx_q;
  assign hit_y_o     = hy_q;
  assign hit_z_o     = hz_q;
  assign hit_param_o = hp_q;

  `SIT_ASSERT_NEXT(a_result_latency, clk_i, rst_ni, start_i, ##(LAT-1) valid_o)
  `SIT_ASSERT(a_no_spurious_result, clk_i, rst_ni, !start_i |-> ##LAT !valid_o)
  `SIT_ASSERT(a_miss_is_zero, clk_i, rst_ni,
              valid_o && (hit_class_o == sit_pkg::CLS_NONE) |->
              ({hit_x_o, hit_y_o, hit_z_o, hit_param_o} == '0))

endmodule

/* dv/segment_intersect_with_tolerance_tb.sv */
// Self-checking testbench for segment_intersect_with_tolerance: directed and random segment
// pairs under several register settings, checked against an exact wide-integer predictor.
// Depends on sit_pkg and the RTL of the block.
module segment_intersect_with_tolerance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int ONE = 65536;
  localparam int LATENCY = CW + 15;
  localparam int CYCLE_LIMIT = 400000;
  localparam int AX = 0, AY = 1, AZ = 2, BX = 3, BY = 4, BZ = 5;
  localparam int CX = 6, CY = 7, CZ = 8, DX = 9, DY = 10, DZ = 11;

  typedef logic signed [191:0] wide_t;
  typedef struct { logic signed [CW-1:0] c [12]; } seg_pair_t;
  typedef struct {
    sit_pkg::hit_class_e cls;
    logic signed [CW-1:0] x, y, z;
    logic signed [sit_pkg::PARAM_WIDTH-1:0] p;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, valid_o, cfg_ready_o;
  logic signed [CW-1:0] ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  logic signed [CW-1:0] cx_i = '0, cy_i = '0, cz_i = '0, dx_i = '0, dy_i = '0, dz_i = '0;
  logic [1:0] hit_class_o;
  logic signed [CW-1:0] hit_x_o, hit_y_o, hit_z_o;
  logic signed [sit_pkg::PARAM_WIDTH-1:0] hit_param_o;
  logic cfg_valid_i = 1'b0;
  logic [sit_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sit_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  seg_pair_t pending_pairs[$];
  hit_t predicted_hits[$];
  seg_pair_t cur_pair;
  logic [sit_pkg::TOL_WIDTH-1:0] tol_reg = '0;
  logic z_first_reg = 1'b1;
  int gap_left = 0;
  bit burst = 0;
  int mismatches = 0;
  int cycles = 0;

  segment_intersect_with_tolerance #(.COORD_WIDTH(CW)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic wide_t floor_div(wide_t m, wide_t d);
    wide_t q;
    q = m / d;
    if (m < 0 && q * d != m) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    wide_t hi, lo;
    hi = 192'sd2147483647;
    lo = -192'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bit near_pt(wide_t xr, wide_t yr, wide_t px, wide_t py, wide_t tol);
    wide_t ex, ey;
    ex = xr - px;
    ey = yr - py;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    return ex <= tol && ey <= tol;
  endfunction

  function automatic hit_t intersect_xy(seg_pair_t s, logic [sit_pkg::TOL_WIDTH-1:0] tol_v,
                                        logic zf);
    wide_t c [12];
    wide_t v1x, v1y, v1z, v2x, v2y, v2z, wx, wy, del, n1, n2, xr, yr, zr, tp, tol;
    hit_t h;
    h = '{sit_pkg::CLS_NONE, '0, '0, '0, '0};
    for (int i = 0; i < 12; i++) c[i] = s.c[i];
    v1x = c[BX] - c[AX]; v1y = c[BY] - c[AY]; v1z = c[BZ] - c[AZ];
    v2x = c[DX] - c[CX]; v2y = c[DY] - c[CY]; v2z = c[DZ] - c[CZ];
    wx = c[CX] - c[AX]; wy = c[CY] - c[AY];
    del = v1x * v2y - v1y * v2x;
    if (del == 0) return h;
    n1 = wx * v2y - wy * v2x;
    n2 = wx * v1y - wy * v1x;
    if (del < 0) begin
      del = -del; n1 = -n1; n2 = -n2;
    end
    xr = c[AX] + floor_div(n1 * v1x, del);
    yr = c[AY] + floor_div(n1 * v1y, del);
    tol = {161'b0, tol_v};
    if (n2 < 0 || n2 > del) begin
      if (!near_pt(xr, yr, c[CX], c[CY], tol) && !near_pt(xr, yr, c[DX], c[DY], tol)) return h;
    end
    h.cls = sit_pkg::CLS_INTERIOR;
    if (n1 <= 0 || n1 >= del) begin
      if (near_pt(xr, yr, c[AX], c[AY], tol)) h.cls = sit_pkg::CLS_AT_START;
      else if (near_pt(xr, yr, c[BX], c[BY], tol)) h.cls = sit_pkg::CLS_AT_END;
      else begin
        h.cls = sit_pkg::CLS_NONE;
        return h;
      end
    end
    if (zf) zr = c[AZ] + floor_div(n1 * v1z, del);
    else zr = c[CZ] + floor_div(n2 * v2z, del);
    tp = floor_div(n1 * (192'sd1 <<< sit_pkg::PARAM_FRAC), del);
    h.x = sat32(xr);
    h.y = sat32(yr);
    h.z = sat32(zr);
    h.p = sat32(tp);
    return h;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) predicted_hits.push_back(intersect_xy(cur_pair, tol_reg, z_first_reg));
      if (start_i && busy_o) begin
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() > 0) begin
        cur_pair = pending_pairs.pop_front();
        ax_i <= cur_pair.c[AX]; ay_i <= cur_pair.c[AY]; az_i <= cur_pair.c[AZ];
        bx_i <= cur_pair.c[BX]; by_i <= cur_pair.c[BY]; bz_i <= cur_pair.c[BZ];
        cx_i <= cur_pair.c[CX]; cy_i <= cur_pair.c[CY]; cz_i <= cur_pair.c[CZ];
        dx_i <= cur_pair.c[DX]; dy_i <= cur_pair.c[DY]; dz_i <= cur_pair.c[DZ];
        start_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap_left <= burst ? 0 : $urandom_range(0, 18);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    hit_t h;
    if (rst_ni && valid_o) begin
      if (predicted_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, class %0d", hit_class_o);
      end else begin
        h = predicted_hits.pop_front();
        if (hit_class_o != h.cls || hit_x_o != h.x || hit_y_o != h.y || hit_z_o != h.z ||
            hit_param_o != h.p) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cls %0d x %0d y %0d z %0d t %0d, got %0d %0d %0d %0d %0d",
                     h.cls, h.x, h.y, h.z, h.p,
                     hit_class_o, hit_x_o, hit_y_o, hit_z_o, hit_param_o);
        end
      end
    end
  end

  function automatic int srange(int r);
    return $signed($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic seg_pair_t pair_of(int v [12]);
    seg_pair_t s;
    for (int i = 0; i < 12; i++) s.c[i] = v[i];
    return s;
  endfunction

  function automatic seg_pair_t random_pair(int snap);
    seg_pair_t s;
    int k, sel, r;
    sel = $urandom_range(0, 99);
    r = 1 << $urandom_range(4, 22);
    for (int i = 0; i < 12; i++) s.c[i] = srange(r);
    for (int i = AZ; i < 12; i += 3) if ($urandom_range(0, 3) == 0) s.c[i] = $urandom;
    if (sel < 15) begin
      for (int i = 0; i < 12; i++) s.c[i] = $urandom;
    end else if (sel < 45) begin
      k = $urandom_range(0, 1) ? AX : BX;
      if ($urandom_range(0, 1)) begin
        s.c[CX] = s.c[k] + srange(snap); s.c[CY] = s.c[k + 1] + srange(snap);
      end else begin
        s.c[DX] = s.c[k] + srange(snap); s.c[DY] = s.c[k + 1] + srange(snap);
      end
    end else if (sel < 55) begin
      k = srange(3);
      s.c[DX] = s.c[CX] + k * (s.c[BX] - s.c[AX]);
      s.c[DY] = s.c[CY] + k * (s.c[BY] - s.c[AY]);
    end
    return s;
  endfunction

  task automatic write_reg(logic [sit_pkg::CFG_IDX_W-1:0] idx,
                           logic [sit_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == sit_pkg::CFG_TOLERANCE) tol_reg = data[sit_pkg::TOL_WIDTH-1:0];
    else if (idx == sit_pkg::CFG_Z_FROM_FIRST) z_first_reg = data[0];
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !start_i && predicted_hits.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    int mx, mn, tol_v, snap;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_pairs.push_back(pair_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 4*ONE, 8*ONE,
                                      0, 4*ONE, 2*ONE, 4*ONE, 0, 6*ONE}));
    pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 0, 0, 0, ONE, 0, 4*ONE, ONE, 0}));
    pending_pairs.push_back(pair_of('{0, 0, ONE, 4*ONE, 0, 3*ONE,
                                      0, -2*ONE, 5, 0, 2*ONE, -5}));
    pending_pairs.push_back(pair_of('{0, 0, ONE, 4*ONE, 0, 3*ONE,
                                      4*ONE, -2*ONE, 5, 4*ONE, 2*ONE, -5}));
    pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 0, 0, 6*ONE, -2*ONE, 0, 6*ONE, 2*ONE, 0}));
    pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 0, 0, 2*ONE, ONE, 0, 2*ONE, 3*ONE, 0}));
    pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 0, 0, 2*ONE, 0, 0, 2*ONE, 3*ONE, 0}));
    pending_pairs.push_back(pair_of('{mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mn}));
    pending_pairs.push_back(pair_of('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx}));
    pending_pairs.push_back(pair_of('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    pending_pairs.push_back(pair_of('{mx, 0, mn, mx - 1, 1, mx, mx, 2, mx, mn, -2, mn}));
    pending_pairs.push_back(pair_of('{-1, -1, -1, 1, 1, 1, -1, 1, -1, 1, -1, 1}));
    for (int i = 0; i < 200; i++) pending_pairs.push_back(random_pair(1 << 8));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tol_v = 32'hffffffff;
          write_reg(sit_pkg::CFG_TOLERANCE, tol_v);
          write_reg(sit_pkg::CFG_Z_FROM_FIRST, 32'hfffffffe);
          snap = 1 << 20;
        end
        1: begin
          tol_v = $urandom_range(1, 1 << 14);
          write_reg(sit_pkg::CFG_TOLERANCE, tol_v);
          write_reg(sit_pkg::CFG_Z_FROM_FIRST, 32'h1);
          snap = tol_v * 2;
        end
        default: begin
          tol_v = $urandom_range(0, 1 << 16);
          write_reg(sit_pkg::CFG_Z_FROM_FIRST, 32'h0);
          write_reg(sit_pkg::CFG_TOLERANCE, tol_v);
          snap = tol_v + 4;
        end
      endcase
      pending_pairs.push_back(pair_of('{0, 0, 0, 4*ONE, 0, 0,
                                        2*ONE, ONE, 0, 2*ONE, 3*ONE, ONE}));
      for (int i = 0; i < 210; i++) pending_pairs.push_back(random_pair(snap));
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_delay.sv
rtl/sit_mulw.sv
rtl/sit_fdiv.sv
rtl/segment_intersect_with_tolerance.sv
dv/segment_intersect_with_tolerance_tb.sv
